// ===== rtl/cvs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvs_pkg
// Shared types, codes and constants for the chunked voxel store.
// ----------------------------------------------------------------------------
package cvs_pkg;

  // Default geometry
  localparam int unsigned CHUNK_SIZE_X_DEF = 16;
  localparam int unsigned CHUNK_SIZE_Y_DEF = 16;
  localparam int unsigned CHUNK_SIZE_Z_DEF = 16;
  localparam int unsigned MAX_CHUNKS_DEF   = 64;
  localparam int unsigned BLOCK_BITS_DEF   = 8;

  // Fixed field widths
  localparam int unsigned COORD_W    = 16;  // world voxel coordinate
  localparam int unsigned DIM_W      = 7;   // grid dimension register
  localparam int unsigned ORIGIN_W   = 12;  // grid origin register
  localparam int unsigned ID_W       = 8;   // block id on the ports
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned REL_W      = 18;  // chunk coordinate minus origin
  localparam int unsigned LOCAL_W    = 7;   // chunk coordinate inside the grid
  localparam int unsigned GRID_T_W   = 14;  // z + dimz*y
  localparam int unsigned SLOT_FULL_W = 21; // x + dimx*(z + dimz*y)

  // Cycles from item registers to a valid voxel address
  localparam int unsigned IDX_LAT = 7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X   = 3'd0,
    CFG_GRID_Y   = 3'd1,
    CFG_GRID_Z   = 3'd2,
    CFG_ORIGIN_X = 3'd3,
    CFG_ORIGIN_Y = 3'd4,
    CFG_ORIGIN_Z = 3'd5
  } cfg_reg_t;

  // Grid configuration as seen by the address path
  typedef struct packed {
    logic        [DIM_W-1:0]    grid_x;
    logic        [DIM_W-1:0]    grid_y;
    logic        [DIM_W-1:0]    grid_z;
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
    logic signed [ORIGIN_W-1:0] origin_z;
  } cvs_cfg_t;

  // Top level sequencer
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_UPDATE
  } cvs_state_t;

  // Bits needed to index n entries (at least one)
  function automatic int unsigned bits_for(longint unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic longint unsigned voxels_per_chunk(int unsigned sx, int unsigned sy,
                                                       int unsigned sz);
    return longint'(sx) * longint'(sy) * longint'(sz);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cvs_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvs_ram
// Generic single-port synchronous RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module cvs_ram
  import cvs_pkg::*;
#(
  parameter int unsigned           WIDTH = BLOCK_BITS_DEF,
  parameter longint unsigned       DEPTH = 262144
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [bits_for(DEPTH)-1:0]   addr,
  input  wire logic [WIDTH-1:0]             wdata,
  output      logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/cvs_floor_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvs_floor_div
// Three-stage floor divide and floor modulo of a signed coordinate by a
// constant, via reciprocal multiply and a single correction step.
// ----------------------------------------------------------------------------
module cvs_floor_div
  import cvs_pkg::*;
#(
  parameter int unsigned DIVISOR = CHUNK_SIZE_X_DEF
) (
  input  wire logic                              clk,
  input  wire logic signed [COORD_W-1:0]         a,
  output      logic signed [COORD_W-1:0]         q,
  output      logic [bits_for(DIVISOR)-1:0]      rem
);

  localparam int unsigned     MAG_W    = COORD_W - 1;
  localparam int unsigned     RECIP_SH = COORD_W;
  localparam int unsigned     RECIP_W  = RECIP_SH + 1;
  localparam longint unsigned RECIP    = (64'd1 << RECIP_SH) / DIVISOR;
  localparam int unsigned     PROD_W   = MAG_W + RECIP_W;
  localparam int unsigned     REM_W    = bits_for(DIVISOR);

  // Stage 1: fold negatives onto -a-1, multiply by reciprocal
  logic              neg1_r, neg1_nxt;
  logic [MAG_W-1:0]  mag1_r, mag1_nxt;
  logic [PROD_W-1:0] prod1_r, prod1_nxt;

  always_comb begin
    neg1_nxt  = a[COORD_W-1];
    mag1_nxt  = a[COORD_W-1] ? ~a[MAG_W-1:0] : a[MAG_W-1:0];
    prod1_nxt = PROD_W'(mag1_nxt) * PROD_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    neg1_r  <= neg1_nxt;
    mag1_r  <= mag1_nxt;
    prod1_r <= prod1_nxt;
  end

  // Stage 2: quotient estimate (exact or one low) and its back product
  logic             neg2_r;
  logic [MAG_W-1:0] mag2_r;
  logic [MAG_W-1:0] qe2_r, qe2_nxt;
  logic [MAG_W-1:0] qc2_r, qc2_nxt;

  always_comb begin
    qe2_nxt = prod1_r[RECIP_SH +: MAG_W];
    qc2_nxt = qe2_nxt * MAG_W'(DIVISOR);
  end

  always_ff @(posedge clk) begin
    neg2_r <= neg1_r;
    mag2_r <= mag1_r;
    qe2_r  <= qe2_nxt;
    qc2_r  <= qc2_nxt;
  end

  // Stage 3: correct, then unfold the sign
  logic [MAG_W-1:0]          diff;
  logic                      fix;
  logic [MAG_W-1:0]          qm;
  logic [MAG_W-1:0]          rm;
  logic signed [COORD_W-1:0] q_nxt;
  logic [REM_W-1:0]          rem_nxt;

  always_comb begin
    diff    = mag2_r - qc2_r;
    fix     = (diff >= MAG_W'(DIVISOR));
    qm      = fix ? (qe2_r + MAG_W'(1)) : qe2_r;
    rm      = fix ? (diff - MAG_W'(DIVISOR)) : diff;
    q_nxt   = neg2_r ? ~{1'b0, qm} : {1'b0, qm};
    rem_nxt = neg2_r ? (REM_W'(DIVISOR - 1) - rm[REM_W-1:0]) : rm[REM_W-1:0];
  end

  always_ff @(posedge clk) begin
    q   <= q_nxt;
    rem <= rem_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/cvs_index.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cvs_index
// Address path: world coordinate to chunk coordinate, grid bounds check,
// chunk slot and voxel address.
// ----------------------------------------------------------------------------
module cvs_index
  import cvs_pkg::*;
#(
  parameter int unsigned CHUNK_SIZE_X = CHUNK_SIZE_X_DEF,
  parameter int unsigned CHUNK_SIZE_Y = CHUNK_SIZE_Y_DEF,
  parameter int unsigned CHUNK_SIZE_Z = CHUNK_SIZE_Z_DEF,
  parameter int unsigned MAX_CHUNKS   = MAX_CHUNKS_DEF
) (
  input  wire logic                      clk,
  input  wire cvs_cfg_t                  cfg,
  input  wire logic signed [COORD_W-1:0] world_x,
  input  wire logic signed [COORD_W-1:0] world_y,
  input  wire logic signed [COORD_W-1:0] world_z,
  output      logic [bits_for(longint'(MAX_CHUNKS) *
                     voxels_per_chunk(CHUNK_SIZE_X, CHUNK_SIZE_Y, CHUNK_SIZE_Z))-1:0] addr,
  output      logic                      in_grid
);

  localparam longint unsigned VPC    = voxels_per_chunk(CHUNK_SIZE_X, CHUNK_SIZE_Y,
                                                        CHUNK_SIZE_Z);
  localparam int unsigned     ADDR_W = bits_for(longint'(MAX_CHUNKS) * VPC);
  localparam int unsigned     LOC_W  = bits_for(VPC);
  localparam int unsigned     SLOT_W = bits_for(MAX_CHUNKS);
  localparam int unsigned     VX_W   = bits_for(CHUNK_SIZE_X);
  localparam int unsigned     VY_W   = bits_for(CHUNK_SIZE_Y);
  localparam int unsigned     VZ_W   = bits_for(CHUNK_SIZE_Z);

  // Floor divide on each axis (stages 1 to 3)
  logic signed [COORD_W-1:0] cx, cy, cz;
  logic [VX_W-1:0]           vx;
  logic [VY_W-1:0]           vy;
  logic [VZ_W-1:0]           vz;

  cvs_floor_div #(.DIVISOR(CHUNK_SIZE_X)) u_div_x (.clk(clk), .a(world_x), .q(cx), .rem(vx));
  cvs_floor_div #(.DIVISOR(CHUNK_SIZE_Y)) u_div_y (.clk(clk), .a(world_y), .q(cy), .rem(vy));
  cvs_floor_div #(.DIVISOR(CHUNK_SIZE_Z)) u_div_z (.clk(clk), .a(world_z), .q(cz), .rem(vz));

  // A zero dimension counts as one chunk
  logic [DIM_W-1:0] dim_x, dim_y, dim_z;

  always_comb begin
    dim_x = (cfg.grid_x == '0) ? DIM_W'(1) : cfg.grid_x;
    dim_y = (cfg.grid_y == '0) ? DIM_W'(1) : cfg.grid_y;
    dim_z = (cfg.grid_z == '0) ? DIM_W'(1) : cfg.grid_z;
  end

  // Stage 4: relative chunk coordinate and bounds, in-chunk z/y part
  logic signed [REL_W-1:0] rel_x, rel_y, rel_z;
  logic                    in_x, in_y, in_z;
  logic [LOCAL_W-1:0]      lx4_r, ly4_r, lz4_r;
  logic                    ok4_r, ok4_nxt;
  logic [LOC_W-1:0]        zy4_r, zy4_nxt;
  logic [VX_W-1:0]         vx4_r;

  always_comb begin
    rel_x   = REL_W'(cx) - REL_W'(cfg.origin_x);
    rel_y   = REL_W'(cy) - REL_W'(cfg.origin_y);
    rel_z   = REL_W'(cz) - REL_W'(cfg.origin_z);
    in_x    = !rel_x[REL_W-1] && (rel_x[REL_W-2:0] < (REL_W-1)'(dim_x));
    in_y    = !rel_y[REL_W-1] && (rel_y[REL_W-2:0] < (REL_W-1)'(dim_y));
    in_z    = !rel_z[REL_W-1] && (rel_z[REL_W-2:0] < (REL_W-1)'(dim_z));
    ok4_nxt = in_x && in_y && in_z;
    zy4_nxt = LOC_W'(vz) + LOC_W'(CHUNK_SIZE_Z) * LOC_W'(vy);
  end

  always_ff @(posedge clk) begin
    lx4_r <= rel_x[LOCAL_W-1:0];
    ly4_r <= rel_y[LOCAL_W-1:0];
    lz4_r <= rel_z[LOCAL_W-1:0];
    ok4_r <= ok4_nxt;
    zy4_r <= zy4_nxt;
    vx4_r <= vx;
  end

  // Stage 5: z + dimz*y, and the voxel offset inside the chunk
  logic [GRID_T_W-1:0] t5_r, t5_nxt;
  logic [LOC_W-1:0]    loc5_r, loc5_nxt;
  logic [LOCAL_W-1:0]  lx5_r;
  logic                ok5_r;

  always_comb begin
    t5_nxt   = GRID_T_W'(lz4_r) + GRID_T_W'(dim_z) * GRID_T_W'(ly4_r);
    loc5_nxt = LOC_W'(vx4_r) + LOC_W'(CHUNK_SIZE_X) * zy4_r;
  end

  always_ff @(posedge clk) begin
    t5_r   <= t5_nxt;
    loc5_r <= loc5_nxt;
    lx5_r  <= lx4_r;
    ok5_r  <= ok4_r;
  end

  // Stage 6: chunk slot and its limit
  logic [SLOT_FULL_W-1:0] slot_full;
  logic [SLOT_W-1:0]      slot6_r;
  logic                   ok6_r, ok6_nxt;
  logic [LOC_W-1:0]       loc6_r;

  always_comb begin
    slot_full = SLOT_FULL_W'(lx5_r) + SLOT_FULL_W'(dim_x) * SLOT_FULL_W'(t5_r);
    ok6_nxt   = ok5_r && (slot_full < SLOT_FULL_W'(MAX_CHUNKS));
  end

  always_ff @(posedge clk) begin
    slot6_r <= slot_full[SLOT_W-1:0];
    ok6_r   <= ok6_nxt;
    loc6_r  <= loc5_r;
  end

  // Stage 7: voxel address
  logic [ADDR_W-1:0] addr_nxt;

  always_comb begin
    addr_nxt = ADDR_W'(slot6_r) * ADDR_W'(VPC) + ADDR_W'(loc6_r);
  end

  always_ff @(posedge clk) begin
    addr    <= addr_nxt;
    in_grid <= ok6_r;
  end

endmodule
`default_nettype wire

// ===== rtl/chunked_voxel_store.sv =====
`default_nettype none
// Items are taken one at a time: an input beat is registered, passes the
// 7-stage address path, then one RAM read and a write-back, and only then is
// in_ready raised again; the write-back waits while a result beat is held.
// Reset: config, sequencer and out_valid registers reset, then a clearing pass
// writes air to all MAX_CHUNKS*CHUNK_SIZE_X*CHUNK_SIZE_Y*CHUNK_SIZE_Z voxels
// (262144 by default), with in_ready low; configuration writes still land.
// ----------------------------------------------------------------------------
// chunked_voxel_store
// Voxel store laid out as a grid of chunks: read or write one voxel per item
// at a signed world coordinate, with a configurable grid origin and size.
// ----------------------------------------------------------------------------
module chunked_voxel_store
  import cvs_pkg::*;
#(
  parameter int unsigned CHUNK_SIZE_X = CHUNK_SIZE_X_DEF,
  parameter int unsigned CHUNK_SIZE_Y = CHUNK_SIZE_Y_DEF,
  parameter int unsigned CHUNK_SIZE_Z = CHUNK_SIZE_Z_DEF,
  parameter int unsigned MAX_CHUNKS   = MAX_CHUNKS_DEF,
  parameter int unsigned BLOCK_BITS   = BLOCK_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input beats
  input  wire logic                      in_valid,
  output      logic                      in_ready,
  input  wire logic                      in_kind,
  input  wire logic signed [COORD_W-1:0] in_world_x,
  input  wire logic signed [COORD_W-1:0] in_world_y,
  input  wire logic signed [COORD_W-1:0] in_world_z,
  input  wire logic [ID_W-1:0]           in_new_block,
  // result beats
  output      logic                      out_valid,
  input  wire logic                      out_ready,
  output      logic [ID_W-1:0]           out_old_block,
  output      logic                      out_inside_res,
  output      logic                      out_changed,
  // configuration writes
  input  wire logic                      cfg_valid,
  output      logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam longint unsigned VPC       = voxels_per_chunk(CHUNK_SIZE_X, CHUNK_SIZE_Y,
                                                           CHUNK_SIZE_Z);
  localparam longint unsigned MEM_DEPTH = longint'(MAX_CHUNKS) * VPC;
  localparam int unsigned     ADDR_W    = bits_for(MEM_DEPTH);
  localparam int unsigned     CNT_W     = bits_for(IDX_LAT);

  // Configuration registers, always ready
  cvs_cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_GRID_X:   cfg_nxt.grid_x   = cfg_data[DIM_W-1:0];
        CFG_GRID_Y:   cfg_nxt.grid_y   = cfg_data[DIM_W-1:0];
        CFG_GRID_Z:   cfg_nxt.grid_z   = cfg_data[DIM_W-1:0];
        CFG_ORIGIN_X: cfg_nxt.origin_x = cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN_Y: cfg_nxt.origin_y = cfg_data[ORIGIN_W-1:0];
        CFG_ORIGIN_Z: cfg_nxt.origin_z = cfg_data[ORIGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_x   <= DIM_W'(1);
      cfg_r.grid_y   <= DIM_W'(1);
      cfg_r.grid_z   <= DIM_W'(1);
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.origin_z <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Item registers, held for the whole operation
  logic                      in_fire;
  logic                      kind_r;
  logic signed [COORD_W-1:0] wx_r, wy_r, wz_r;
  logic [BLOCK_BITS-1:0]     nb_r;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_kind;
      wx_r   <= in_world_x;
      wy_r   <= in_world_y;
      wz_r   <= in_world_z;
      nb_r   <= BLOCK_BITS'(in_new_block);
    end
  end

  // Address path
  logic [ADDR_W-1:0] idx_addr;
  logic              idx_inside;

  cvs_index #(
    .CHUNK_SIZE_X (CHUNK_SIZE_X),
    .CHUNK_SIZE_Y (CHUNK_SIZE_Y),
    .CHUNK_SIZE_Z (CHUNK_SIZE_Z),
    .MAX_CHUNKS   (MAX_CHUNKS)
  ) u_index (
    .clk     (clk),
    .cfg     (cfg_r),
    .world_x (wx_r),
    .world_y (wy_r),
    .world_z (wz_r),
    .addr    (idx_addr),
    .in_grid (idx_inside)
  );

  // Voxel memory
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_addr;
  logic [BLOCK_BITS-1:0] ram_wdata;
  logic [BLOCK_BITS-1:0] ram_rdata;

  cvs_ram #(
    .WIDTH (BLOCK_BITS),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Sequencer state and counters
  cvs_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              clr_last;
  logic              out_valid_r;
  logic              res_load;
  logic              differs;

  assign clr_last = (clr_r == ADDR_W'(MEM_DEPTH - 1));
  assign differs  = (ram_rdata != nb_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_fire) state_nxt = ST_CALC;
      ST_CALC:   if (cnt_r == CNT_W'(IDX_LAT - 1)) state_nxt = ST_READ;
      ST_READ:   state_nxt = ST_UPDATE;
      ST_UPDATE: if (res_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    res_load  = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = idx_addr;
    ram_wdata = nb_r;
    clr_nxt   = clr_r;
    cnt_nxt   = '0;
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_CALC: begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_READ: ;
      ST_UPDATE: begin
        // write back only a changed id inside the grid
        res_load = !out_valid_r || out_ready;
        ram_we   = res_load && idx_inside && kind_r && differs;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Result register: frees the core while a beat waits downstream
  logic [ID_W-1:0] old_r;
  logic            inside_r;
  logic            changed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      old_r     <= idx_inside ? ID_W'(ram_rdata) : '0;
      inside_r  <= idx_inside;
      changed_r <= idx_inside && kind_r && differs;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_old_block  = old_r;
  assign out_inside_res = inside_r;
  assign out_changed    = changed_r;

endmodule
`default_nettype wire

// ===== verif/chunked_voxel_store_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunked_voxel_store_tb
// Self-checking bench for the chunked voxel store. A queue-fed driver offers
// read and write beats, and a monitor checks each result beat against a
// cycle-free copy of the store held here. Several grid settings are applied
// between drained phases, and both channels are throttled at random.
// ----------------------------------------------------------------------------
module chunked_voxel_store_tb;
  import cvs_pkg::*;

  localparam int SX         = CHUNK_SIZE_X_DEF;
  localparam int SY         = CHUNK_SIZE_Y_DEF;
  localparam int SZ         = CHUNK_SIZE_Z_DEF;
  localparam int CHUNKS     = MAX_CHUNKS_DEF;
  localparam int VOX_CHUNK  = SX * SY * SZ;
  localparam int VOX_DEPTH  = CHUNKS * VOX_CHUNK;
  localparam int ID_MASK    = (1 << BLOCK_BITS_DEF) - 1;
  localparam int RUN_LIMIT  = 1_500_000;
  localparam int SETTLE_CYC = IDX_LAT + 4;

  // Operation codes and the two register indexes the block does not decode
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  // Throttle modes
  localparam int THR_SEND_LIGHT = 0;  // sender idles 13%, receiver 87%
  localparam int THR_SEND_HEAVY = 1;  // sender idles 87%, receiver 13%
  localparam int THR_NONE       = 2;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] wx;
    logic signed [COORD_W-1:0] wy;
    logic signed [COORD_W-1:0] wz;
    logic [ID_W-1:0]           new_block;
  } voxel_op_t;

  typedef struct packed {
    logic [ID_W-1:0] old_block;
    logic            inside_res;
    logic            changed;
  } voxel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  voxel_op_t                 drive_op = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic                      in_kind;
  logic signed [COORD_W-1:0] in_world_x;
  logic signed [COORD_W-1:0] in_world_y;
  logic signed [COORD_W-1:0] in_world_z;
  logic [ID_W-1:0]           in_new_block;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [ID_W-1:0]           out_old_block;
  logic                      out_inside_res;
  logic                      out_changed;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data = '0;

  assign in_kind      = drive_op.kind;
  assign in_world_x   = drive_op.wx;
  assign in_world_y   = drive_op.wy;
  assign in_world_z   = drive_op.wz;
  assign in_new_block = drive_op.new_block;

  // Bench state
  voxel_op_t       op_backlog[$];
  voxel_op_t       recent_ops[$];
  voxel_result_t   awaited_results[$];
  logic [ID_W-1:0] store_copy [VOX_DEPTH];
  cvs_cfg_t        grid_now;
  logic            in_taken = 1'b0;
  int              throttle = THR_SEND_LIGHT;
  int              error_count = 0;
  int              cycle_count = 0;

  chunked_voxel_store i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_world_x     (in_world_x),
    .in_world_y     (in_world_y),
    .in_world_z     (in_world_z),
    .in_new_block   (in_new_block),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_old_block  (out_old_block),
    .out_inside_res (out_inside_res),
    .out_changed    (out_changed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Floor quotient, rounding towards minus infinity
  function automatic int floor_div(input int a, input int d);
    if (a >= 0) return a / d;
    return -((-a - 1) / d) - 1;
  endfunction

  // A zero dimension register counts as one chunk
  function automatic int dim_of(input logic [DIM_W-1:0] r);
    return (r == 0) ? 1 : int'(r);
  endfunction

  // Store copy: work out the result of one beat and apply any write
  task automatic model_voxel_access(input voxel_op_t op);
    int cx, cy, cz, lx, ly, lz, dx, dy, dz, slot, addr, nb;
    voxel_result_t res;
    cx = floor_div(int'(op.wx), SX);
    cy = floor_div(int'(op.wy), SY);
    cz = floor_div(int'(op.wz), SZ);
    lx = cx - int'(grid_now.origin_x);
    ly = cy - int'(grid_now.origin_y);
    lz = cz - int'(grid_now.origin_z);
    dx = dim_of(grid_now.grid_x);
    dy = dim_of(grid_now.grid_y);
    dz = dim_of(grid_now.grid_z);
    nb = int'(op.new_block) & ID_MASK;
    res = '0;
    if (lx >= 0 && lx < dx && ly >= 0 && ly < dy && lz >= 0 && lz < dz) begin
      slot = lx + dx * (lz + dz * ly);
      if (slot < CHUNKS) begin
        addr = slot * VOX_CHUNK + (int'(op.wx) - cx * SX)
             + SX * ((int'(op.wz) - cz * SZ) + SZ * (int'(op.wy) - cy * SY));
        res.old_block  = store_copy[addr];
        res.inside_res = 1'b1;
        if (op.kind == OP_WRITE && int'(store_copy[addr]) != nb) begin
          store_copy[addr] = nb[ID_W-1:0];
          res.changed      = 1'b1;
        end
      end
    end
    awaited_results = {awaited_results, res};
  endtask

  // Random chunk offset: mostly inside, biased to low slots, sometimes just out
  function automatic int pick_local(input int d);
    int r;
    r = $urandom_range(15);
    if (r == 0) return -1;
    if (r == 1) return d;
    if (r < 8) return $urandom_range(d - 1);
    return $urandom_range(((d < 4) ? d : 4) - 1);
  endfunction

  task automatic add_op(input logic kind, input int x, input int y, input int z,
                        input int nb);
    voxel_op_t op;
    op.kind      = kind;
    op.wx        = 16'(x);
    op.wy        = 16'(y);
    op.wz        = 16'(z);
    op.new_block = 8'(nb);
    op_backlog = {op_backlog, op};
  endtask

  // Mostly beats aimed at the grid, some revisiting recent voxels, rest noise
  task automatic queue_random_ops(input int count);
    voxel_op_t op;
    int r, pick;
    for (int i = 0; i < count; i++) begin
      r            = $urandom_range(99);
      op.kind      = 1'($urandom_range(1));
      op.new_block = 8'($urandom_range(255));
      if ($urandom_range(7) == 0) op.new_block = $urandom_range(1) ? 8'hFF : 8'h00;
      if (r < 35 && recent_ops.size() > 0) begin
        pick  = $urandom_range(recent_ops.size() - 1);
        op.wx = recent_ops[pick].wx;
        op.wy = recent_ops[pick].wy;
        op.wz = recent_ops[pick].wz;
        if ($urandom_range(1)) op.new_block = recent_ops[pick].new_block;
      end else if (r < 88) begin
        op.wx = 16'((int'(grid_now.origin_x) + pick_local(dim_of(grid_now.grid_x))) * SX
                    + $urandom_range(SX - 1));
        op.wy = 16'((int'(grid_now.origin_y) + pick_local(dim_of(grid_now.grid_y))) * SY
                    + $urandom_range(SY - 1));
        op.wz = 16'((int'(grid_now.origin_z) + pick_local(dim_of(grid_now.grid_z))) * SZ
                    + $urandom_range(SZ - 1));
      end else begin
        op.wx = 16'($urandom_range(16'hFFFF));
        op.wy = 16'($urandom_range(16'hFFFF));
        op.wz = 16'($urandom_range(16'hFFFF));
      end
      op_backlog = {op_backlog, op};
      recent_ops = {recent_ops, op};
      if (recent_ops.size() > 16) void'(recent_ops.pop_front());
    end
  endtask

  // One register beat; leaves cfg_valid high for a following beat
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!(cfg_valid && cfg_ready)) @(posedge clk);
    case (idx)
      CFG_GRID_X:   grid_now.grid_x   = data[DIM_W-1:0];
      CFG_GRID_Y:   grid_now.grid_y   = data[DIM_W-1:0];
      CFG_GRID_Z:   grid_now.grid_z   = data[DIM_W-1:0];
      CFG_ORIGIN_X: grid_now.origin_x = data[ORIGIN_W-1:0];
      CFG_ORIGIN_Y: grid_now.origin_y = data[ORIGIN_W-1:0];
      CFG_ORIGIN_Z: grid_now.origin_z = data[ORIGIN_W-1:0];
      default: ;
    endcase
  endtask

  // Full grid setting, plus beats to the two undecoded indexes
  task automatic write_grid(input int gx, input int gy, input int gz,
                            input int ox, input int oy, input int oz);
    write_reg(CFG_GRID_X, 12'(gx));
    write_reg(CFG_GRID_Y, 12'(gy));
    write_reg(CFG_GRID_Z, 12'(gz));
    write_reg(CFG_SPARE_LO, 12'($urandom_range(12'hFFF)));
    write_reg(CFG_ORIGIN_X, 12'(ox));
    write_reg(CFG_ORIGIN_Y, 12'(oy));
    write_reg(CFG_ORIGIN_Z, 12'(oz));
    write_reg(CFG_SPARE_HI, 12'($urandom_range(12'hFFF)));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every queued beat is taken and every result has arrived
  task automatic drain();
    while (op_backlog.size() != 0 || awaited_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Input driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (op_backlog.size() != 0 &&
          !(throttle == THR_SEND_LIGHT && $urandom_range(99) < 13) &&
          !(throttle == THR_SEND_HEAVY && $urandom_range(99) < 87)) begin
        drive_op <= op_backlog.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    case (throttle)
      THR_SEND_LIGHT: out_ready <= ($urandom_range(99) >= 87);
      THR_SEND_HEAVY: out_ready <= ($urandom_range(99) >= 13);
      default:        out_ready <= 1'b1;
    endcase
  end

  // Predict on each input beat, check each result beat
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (in_valid && in_ready) model_voxel_access(drive_op);
    if (out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result beat: old_block %0d inside_res %0d changed %0d",
               out_old_block, out_inside_res, out_changed);
        error_count++;
      end else begin
        if (out_old_block !== awaited_results[0].old_block) begin
          $error("old_block: expected %0d, got %0d",
                 awaited_results[0].old_block, out_old_block);
          error_count++;
        end
        if (out_inside_res !== awaited_results[0].inside_res) begin
          $error("inside_res: expected %0d, got %0d",
                 awaited_results[0].inside_res, out_inside_res);
          error_count++;
        end
        if (out_changed !== awaited_results[0].changed) begin
          $error("changed: expected %0d, got %0d",
                 awaited_results[0].changed, out_changed);
          error_count++;
        end
        void'(awaited_results.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("chunked_voxel_store_tb: done, errors");
      $finish;
    end
  end

  initial begin
    foreach (store_copy[i]) store_copy[i] = '0;
    grid_now = '{grid_x: 7'd1, grid_y: 7'd1, grid_z: 7'd1,
                 origin_x: '0, origin_y: '0, origin_z: '0};
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Reset grid: a single chunk at the origin
    throttle = THR_SEND_LIGHT;
    add_op(OP_READ,   0,  0,  0, 0);
    add_op(OP_WRITE,  0,  0,  0, 255);
    add_op(OP_READ,   0,  0,  0, 8'h5A);  // id ignored on a read
    add_op(OP_WRITE,  0,  0,  0, 255);    // same id, nothing stored
    add_op(OP_WRITE, 15, 15, 15, 1);
    add_op(OP_READ,  15, 15, 15, 0);
    add_op(OP_WRITE,  0,  0,  0, 0);
    add_op(OP_READ,  16,  0,  0, 0);      // one chunk past the grid
    add_op(OP_WRITE, -1,  0,  0, 7);      // one voxel below the grid
    add_op(OP_WRITE,  0, 16,  0, 9);
    add_op(OP_READ,   0,  0, -1, 0);
    add_op(OP_READ, -32768, -32768, -32768, 0);
    add_op(OP_READ,  32767,  32767,  32767, 0);
    drain();

    // Zero dimensions at the lowest origin: contents of slot 0 survive
    write_grid(0, 0, 0, -2048, -2048, -2048);
    add_op(OP_READ,  -32753, -32753, -32753, 0);
    add_op(OP_WRITE, -32768, -32768, -32768, 8'hA5);
    add_op(OP_READ,  -32768, -32768, -32768, 0);
    add_op(OP_WRITE, -32752, -32768, -32768, 3);
    drain();

    // Largest dimensions at the highest origin
    write_grid(127, 127, 127, 2047, 2047, 2047);
    add_op(OP_WRITE, 32767, 32767, 32767, 8'h3C);
    add_op(OP_READ,  32752, 32752, 32752, 0);
    add_op(OP_READ,  32767, 32767, 32767, 0);
    drain();

    // Largest dimensions at the origin: slot index limit
    write_grid(127, 127, 127, 0, 0, 0);
    add_op(OP_WRITE, 63 * SX, 0, 0, 17);  // last slot
    add_op(OP_READ,  63 * SX, 0, 0, 0);
    add_op(OP_WRITE, 64 * SX, 0, 0, 18);  // first slot past the store
    add_op(OP_READ,  0, 0, SZ, 0);        // slot 127
    drain();

    // Random phases, one grid setting each
    for (int ph = 0; ph < 8; ph++) begin
      throttle = (ph < 3) ? THR_SEND_LIGHT : (ph < 6) ? THR_SEND_HEAVY : THR_NONE;
      case (ph)
        0: write_grid(4, 4, 4, 0, 0, 0);
        1: write_grid(8, 1, 8, -1, -1, -1);
        2: write_grid($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
                      $urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
        3: write_grid(64, 1, 1, -2048, 0, 2047);
        4: write_grid(2, 16, 2, $urandom_range(4095), $urandom_range(4095),
                      $urandom_range(4095));
        5: write_grid(127, 127, 127, $urandom_range(4095), $urandom_range(4095),
                      $urandom_range(4095));
        6: write_grid($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4),
                      $urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
        default: write_grid(1, 64, 1, 0, 0, 0);
      endcase
      if (ph == 7) begin
        // sender holds off until the block has fully drained
        queue_random_ops(35);
        drain();
        queue_random_ops(35);
      end else begin
        queue_random_ops(70);
      end
      drain();
    end

    if (error_count == 0) begin
      $display("chunked_voxel_store_tb: done, clean");
    end else begin
      $display("chunked_voxel_store_tb: done, errors");
    end
    $finish;
  end

endmodule
